// ===== rtl/ktrk_pkg.sv =====
// ktrk_pkg: shared types and constants for the k-th largest stream tracker
// no dependencies; imported by ktrk_cell and kth_largest_stream_tracker_top
package ktrk_pkg;

  // width of a stream value and of the rank register
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned K_W       = 5;
  // default number of cells in the chain
  localparam int unsigned MAX_K_DEF = 16;

  // what one cell shows its neighbours
  typedef struct packed {
    logic [VAL_W-1:0] val;  // stored value
    logic             le;   // entry is kept and not greater than the request value
  } nbr_t;

  // per-cell control from the top level
  typedef struct packed {
    logic active;  // cell lies below the kept count
    logic en;      // cell takes a new value this cycle
    logic ins;     // insert mode: kept set not yet full
    logic rep;     // replace mode: drop smallest, insert among the rest
  } cell_ctrl_t;

endpackage

// ===== rtl/ktrk_cell.sv =====
// ktrk_cell: one entry of the sorted chain of kept values
// depends on ktrk_pkg (value width, neighbour and control types)
module ktrk_cell (
  input  logic                     clk_i,
  input  logic [ktrk_pkg::VAL_W-1:0] v_i,
  input  ktrk_pkg::cell_ctrl_t     ctrl_i,
  input  ktrk_pkg::nbr_t           lo_i,
  input  ktrk_pkg::nbr_t           hi_i,
  output ktrk_pkg::nbr_t           nbr_o
);
  import ktrk_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  logic             le;

  // kept entry not greater than the incoming value
  assign le = ctrl_i.active && ($signed(val_q) <= $signed(v_i));

  // next value: shift down on replace, shift up on insert
  always_comb begin
    val_d = val_q;
    if (ctrl_i.rep) begin
      if (hi_i.le) begin
        val_d = hi_i.val;
      end else if (le) begin
        val_d = v_i;
      end
    end else if (ctrl_i.ins) begin
      if (le) begin
        val_d = val_q;
      end else if (lo_i.le) begin
        val_d = v_i;
      end else begin
        val_d = lo_i.val;
      end
    end
  end

  // value register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      val_q <= val_d;
    end
  end

  assign nbr_o.val = val_q;
  assign nbr_o.le  = le;

endmodule

// ===== rtl/kth_largest_stream_tracker_top.sv =====
// kth_largest_stream_tracker_top: running k-th largest value of a stream
// depends on ktrk_pkg and ktrk_cell
//
// Usage:
//   Input channel: value_i with in_valid_i / in_stall_o. A request is taken
//   at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: kth_value_o and full_res_o with out_valid_o /
//   out_stall_i. One result per request.
//   Rank register: cfg_we_i writes cfg_wdata_i into k and empties the kept
//   set. A k of zero acts as one, a k above MAX_K acts as MAX_K. Write only
//   while no request is in flight.
// Timing:
//   Result appears in the cycle after the request is taken. One request per
//   cycle is sustained unless a held result stalls the input; of the chain
//   of MAX_K cells, each accepted request updates those up to the kept count
//   (up to k on a replace) together, every cell comparing against the new
//   value and taking its own, its lower or its upper neighbour's value or
//   the new one. While a result is held by out_stall_i the block stalls its
//   input; the result stays stable and the next request is taken at the edge where it leaves.
// Reset: k returns to one, the kept set is empty, no result is pending.
module kth_largest_stream_tracker_top #(
  parameter int unsigned MAX_K = ktrk_pkg::MAX_K_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ktrk_pkg::K_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ktrk_pkg::VAL_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ktrk_pkg::VAL_W-1:0] kth_value_o,
  output logic                       full_res_o
);
  import ktrk_pkg::*;

  localparam int unsigned CW = $clog2(MAX_K + 1);
  localparam int unsigned KX = (CW > K_W) ? CW : K_W;

  logic [K_W-1:0] k_q;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  kk;
  logic [KX-1:0]  k_ext;
  logic           out_valid_q, out_valid_d;
  logic           in_acc, full, lt0;
  cell_ctrl_t     ctrl [MAX_K];
  nbr_t           nbr  [MAX_K];

  // effective rank, clamped to one .. MAX_K
  assign k_ext = KX'(k_q);
  always_comb begin
    priority if (k_q == '0) begin
      kk = CW'(1);
    end else if (k_ext > KX'(MAX_K)) begin
      kk = CW'(MAX_K);
    end else begin
      kk = CW'(k_ext);
    end
  end

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == kk);
  assign lt0        = $signed(nbr[0].val) < $signed(value_i);

  // per-cell control
  for (genvar i = 0; i < MAX_K; i++) begin : g_ctrl
    assign ctrl[i].active = (CW'(i) < count_q);
    assign ctrl[i].ins    = in_acc && !full;
    assign ctrl[i].rep    = in_acc && full && lt0;
    assign ctrl[i].en     = (ctrl[i].ins && (CW'(i) <= count_q))
                         || (ctrl[i].rep && (CW'(i) < kk));
  end

  // chain of cells
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    nbr_t lo, hi;
    if (i == 0) begin : g_lo_edge
      assign lo.val = value_i;
      assign lo.le  = 1'b1;
    end else begin : g_lo
      assign lo = nbr[i-1];
    end
    if (i == MAX_K - 1) begin : g_hi_edge
      assign hi.val = '0;
      assign hi.le  = 1'b0;
    end else begin : g_hi
      assign hi = nbr[i+1];
    end
    ktrk_cell u_cell (
      .clk_i  (clk_i),
      .v_i    (value_i),
      .ctrl_i (ctrl[i]),
      .lo_i   (lo),
      .hi_i   (hi),
      .nbr_o  (nbr[i])
    );
  end

  // kept count and result pending flag
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = '0;
    end else if (in_acc && !full) begin
      count_d = count_q + CW'(1);
    end
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= K_W'(1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result: smallest kept value sits in the first cell
  assign out_valid_o = out_valid_q;
  assign kth_value_o = nbr[0].val;
  assign full_res_o  = full;

`ifndef SYNTHESIS
  a_count_le_k : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kk) else $error("kept count above rank");
  a_valid_has_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0)) else $error("result with empty kept set");
  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o) else $error("accepted request gave no result");
  a_first_two_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_K > 1 && count_q >= CW'(2)) |->
      ($signed(nbr[0].val) <= $signed(nbr[(MAX_K > 1) ? 1 : 0].val)))
    else $error("kept values out of order");
`endif

endmodule
